### rtl/ola_pkg.sv
// Shared types and codes for the ordered list block.
package ola_pkg;

   // Command codes carried by one input beat
   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_DELETE = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_DELETE = 2'd1,
      S_READ   = 2'd2
   } state_type;

   // What every cell of the chain does in a cycle
   typedef enum logic [2:0] {
      CM_HOLD    = 3'd0,
      CM_WRITE   = 3'd1,
      CM_COMPARE = 3'd2,
      CM_CLOSE   = 3'd3,
      CM_ROTATE  = 3'd4
   } cell_mode_type;

   // Control broadcast from the sequencer to the cells
   typedef struct packed {
      cell_mode_type mode;
   } cell_ctl_type;

endpackage

### rtl/ordered_list_append_delete.sv
// Ordered list top level: command sequencer, fill count and the cell chain.
// Append and the unused opcode: one result in the cycle after the beat; busy stays low.
// Delete: compare in the accept cycle, close the gap the next; the result is registered
//   from the close cycle, busy during it (empty list: result in the cycle after, busy stays low).
// Read-out: one word per cycle rotated out of the head cell, count results, each
//   registered from a read state cycle; busy until the last word (empty list: 1 result).
// Synchronous reset clears the fill count, sequencer and strobe; cell words stay undefined.
module ordered_list_append_delete #(
   parameter int CAPACITY   = 32,
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_element,
   output logic               rsp_last
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

   ola_pkg::state_type    state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ola_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic signed [31:0]    rsp_element_ff, rsp_element_in;
   logic                  rsp_last_ff, rsp_last_in;

   ola_pkg::cell_ctl_type          ctl;
   logic signed [DATA_WIDTH-1:0]   key;
   logic signed [DATA_WIDTH-1:0]   cell_data [CAPACITY];
   logic                           hit [CAPACITY+1];
   logic                           accept;

   assign accept = start && (state_ff == ola_pkg::S_IDLE);
   assign key    = DATA_WIDTH'(req_value);
   assign hit[0] = 1'b0;

   // Cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_WIDTH-1:0] nbr;
      if (i == CAPACITY - 1) begin : g_end
         assign nbr = cell_data[i];
      end else begin : g_mid
         assign nbr = cell_data[i+1];
      end
      ola_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .CNT_W      (CNT_W),
         .INDEX      (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .count     (count_ff),
         .key       (key),
         .next_data (nbr),
         .head_data (cell_data[0]),
         .hit_in    (hit[i]),
         .hit_out   (hit[i+1]),
         .data      (cell_data[i])
      );
   end

   // Sequencer: next state, cell control and result beat
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      rd_cnt_in      = rd_cnt_ff;
      ctl.mode       = ola_pkg::CM_HOLD;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = ola_pkg::ST_OK;
      rsp_element_in = '0;
      rsp_last_in    = 1'b1;
      unique case (state_ff)
         ola_pkg::S_IDLE: begin
            if (start) begin
               unique case (ola_pkg::opcode_type'(req_opcode))
                  ola_pkg::OP_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == FULL_CNT) begin
                        rsp_status_in = ola_pkg::ST_FULL;
                     end else begin
                        ctl.mode = ola_pkg::CM_WRITE;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ola_pkg::OP_DELETE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ola_pkg::ST_EMPTY;
                     end else begin
                        ctl.mode = ola_pkg::CM_COMPARE;
                        state_in = ola_pkg::S_DELETE;
                     end
                  end
                  ola_pkg::OP_READ: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ola_pkg::ST_EMPTY;
                     end else begin
                        rd_cnt_in = '0;
                        state_in  = ola_pkg::S_READ;
                     end
                  end
                  ola_pkg::OP_NONE: begin
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ola_pkg::S_DELETE: begin
            ctl.mode     = ola_pkg::CM_CLOSE;
            rsp_valid_in = 1'b1;
            state_in     = ola_pkg::S_IDLE;
            if (hit[CAPACITY]) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               rsp_status_in = ola_pkg::ST_NOT_FOUND;
            end
         end
         ola_pkg::S_READ: begin
            ctl.mode       = ola_pkg::CM_ROTATE;
            rsp_valid_in   = 1'b1;
            rsp_element_in = 32'(cell_data[0]);
            rsp_last_in    = (rd_cnt_ff + CNT_W'(1) == count_ff);
            rd_cnt_in      = rd_cnt_ff + CNT_W'(1);
            if (rsp_last_in) state_in = ola_pkg::S_IDLE;
         end
         default: begin
            state_in = ola_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ola_pkg::S_IDLE;
         count_ff     <= '0;
         rd_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_cnt_ff    <= rd_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign busy        = (state_ff != ola_pkg::S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_last    = rsp_last_ff;

   // Fill count never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("fill count above capacity");

   // Delete finishes with a single last beat in the following cycle
   a_delete_beat: assert property (@(posedge clock) disable iff (reset)
      state_ff == ola_pkg::S_DELETE |=> rsp_valid && rsp_last && !busy)
      else $error("delete did not close with one result");

   // Read-out never runs past the stored words
   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ola_pkg::S_READ |-> rd_cnt_ff < count_ff)
      else $error("read-out index past tail");

   // A successful append grows the list by exactly one
   a_append_grow: assert property (@(posedge clock) disable iff (reset)
      accept && req_opcode == ola_pkg::OP_APPEND && count_ff != FULL_CNT
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("append did not grow the list");

endmodule

### rtl/ola_cell.sv
// One storage cell of the list chain: holds a word and a registered match flag.
module ola_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = 6,
   parameter int INDEX      = 0
) (
   input  logic                          clock,
   input  ola_pkg::cell_ctl_type         ctl,
   input  logic [CNT_W-1:0]              count,
   input  logic signed [DATA_WIDTH-1:0]  key,
   input  logic signed [DATA_WIDTH-1:0]  next_data,
   input  logic signed [DATA_WIDTH-1:0]  head_data,
   input  logic                          hit_in,
   output logic                          hit_out,
   output logic signed [DATA_WIDTH-1:0]  data
);

   localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] TAIL_CNT = CNT_W'(INDEX + 1);

   logic signed [DATA_WIDTH-1:0] data_ff, data_in;
   logic                         match_ff, match_in;

   // Per-cell action for the current cycle
   always_comb begin
      data_in  = data_ff;
      match_in = match_ff;
      unique case (ctl.mode)
         ola_pkg::CM_HOLD: begin
         end
         ola_pkg::CM_WRITE: begin
            if (count == MY_IDX) data_in = key;
         end
         ola_pkg::CM_COMPARE: begin
            match_in = (data_ff == key) && (MY_IDX < count);
         end
         ola_pkg::CM_CLOSE: begin
            // at or past the first match: pull the neighbor's word in
            if (hit_in || match_ff) data_in = next_data;
         end
         ola_pkg::CM_ROTATE: begin
            // tail cell takes the head word, the rest shift toward the head
            data_in = (count == TAIL_CNT) ? head_data : next_data;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   // first-match chain toward the tail
   assign hit_out = hit_in || match_ff;
   assign data    = data_ff;

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the ordered list block: directed table, then random commands.
`timescale 1ns / 1ps

module tb_top;

   localparam int LIST_CAP    = 32;
   localparam int WORD_W      = 32;
   localparam int RANDOM_CMDS = 186;
   localparam int CYCLE_LIMIT = 200000;

   // One expected result beat
   typedef struct packed {
      ola_pkg::status_type status;
      logic [31:0]         element;
      logic                last;
   } list_result_type;

   // One row of the directed table; typed rows carry their single result
   typedef struct packed {
      ola_pkg::opcode_type op;
      logic [31:0]         word;
      logic                typed;
      ola_pkg::status_type tst;
   } step_row_type;

   localparam int N_ROWS = 24;
   localparam step_row_type DIRECTED [N_ROWS] = '{
      '{ola_pkg::OP_READ,   32'h0000_0000, 1'b1, ola_pkg::ST_EMPTY},
      '{ola_pkg::OP_DELETE, 32'h0000_0005, 1'b1, ola_pkg::ST_EMPTY},
      '{ola_pkg::OP_NONE,   32'h0000_0000, 1'b1, ola_pkg::ST_OK},
      '{ola_pkg::OP_APPEND, 32'h7fff_ffff, 1'b0, ola_pkg::ST_OK},
      '{ola_pkg::OP_APPEND, 32'h8000_0000, 1'b0, ola_pkg::ST_OK},
      '{ola_pkg::OP_APPEND, 32'h0000_0000, 1'b0, ola_pkg::ST_OK},
      '{ola_pkg::OP_APPEND, 32'hffff_ffff, 1'b0, ola_pkg::ST_OK},
      '{ola_pkg::OP_APPEND, 32'h8000_0000, 1'b0, ola_pkg::ST_OK},
      '{ola_pkg::OP_READ,   32'h0000_0000, 1'b0, ola_pkg::ST_OK},
      '{ola_pkg::OP_DELETE, 32'h0000_3039, 1'b1, ola_pkg::ST_NOT_FOUND},
      '{ola_pkg::OP_DELETE, 32'h8000_0000, 1'b0, ola_pkg::ST_OK},
      '{ola_pkg::OP_READ,   32'hffff_ffff, 1'b0, ola_pkg::ST_OK},
      '{ola_pkg::OP_DELETE, 32'h7fff_ffff, 1'b0, ola_pkg::ST_OK},
      '{ola_pkg::OP_DELETE, 32'h8000_0000, 1'b0, ola_pkg::ST_OK},
      '{ola_pkg::OP_NONE,   32'hffff_ffff, 1'b1, ola_pkg::ST_OK},
      '{ola_pkg::OP_READ,   32'h0000_0000, 1'b0, ola_pkg::ST_OK},
      '{ola_pkg::OP_DELETE, 32'hffff_ffff, 1'b0, ola_pkg::ST_OK},
      '{ola_pkg::OP_DELETE, 32'h0000_0000, 1'b0, ola_pkg::ST_OK},
      '{ola_pkg::OP_DELETE, 32'h0000_0000, 1'b1, ola_pkg::ST_EMPTY},
      '{ola_pkg::OP_READ,   32'h0000_0000, 1'b1, ola_pkg::ST_EMPTY},
      '{ola_pkg::OP_APPEND, 32'ha5a5_a5a5, 1'b0, ola_pkg::ST_OK},
      '{ola_pkg::OP_READ,   32'h0000_0000, 1'b0, ola_pkg::ST_OK},
      '{ola_pkg::OP_DELETE, 32'h5a5a_5a5a, 1'b1, ola_pkg::ST_NOT_FOUND},
      '{ola_pkg::OP_DELETE, 32'ha5a5_a5a5, 1'b0, ola_pkg::ST_OK}
   };

   // Random phases: grow to full, drain, mixed traffic, then grow again
   typedef enum logic [1:0] {
      MIX_GROW   = 2'd0,
      MIX_SHRINK = 2'd1,
      MIX_ANY    = 2'd2
   } traffic_mix_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_opcode = ola_pkg::OP_APPEND;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_element;
   logic               rsp_last;

   logic [31:0]     held_words[$];   // predicted list contents, head first
   list_result_type due_results[$];  // results still to come, oldest first
   int              error_count = 0;
   int              results_checked = 0;
   int              full_reads = 0;
   int              full_appends = 0;
   int              cycle_count = 0;
   bit              idle_enable = 1'b1;

   ordered_list_append_delete #(
      .CAPACITY   (LIST_CAP),
      .DATA_WIDTH (WORD_W)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_opcode  (req_opcode),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_status  (rsp_status),
      .rsp_element (rsp_element),
      .rsp_last    (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one command to the predicted list; queue its results when asked
   function automatic void apply_list_command(input ola_pkg::opcode_type op,
                                              input logic [31:0] word,
                                              input bit record);
      int hit;
      hit = -1;
      case (op)
         ola_pkg::OP_APPEND: begin
            if (held_words.size() >= LIST_CAP) begin
               full_appends++;
               if (record) due_results.push_back('{ola_pkg::ST_FULL, 32'd0, 1'b1});
            end else begin
               held_words.push_back(word);
               if (record) due_results.push_back('{ola_pkg::ST_OK, 32'd0, 1'b1});
            end
         end
         ola_pkg::OP_DELETE: begin
            if (held_words.size() == 0) begin
               if (record) due_results.push_back('{ola_pkg::ST_EMPTY, 32'd0, 1'b1});
            end else begin
               for (int i = 0; i < held_words.size(); i++) begin
                  if (hit < 0 && held_words[i] == word) hit = i;
               end
               if (hit < 0) begin
                  if (record)
                     due_results.push_back('{ola_pkg::ST_NOT_FOUND, 32'd0, 1'b1});
               end else begin
                  held_words.delete(hit);
                  if (record) due_results.push_back('{ola_pkg::ST_OK, 32'd0, 1'b1});
               end
            end
         end
         ola_pkg::OP_READ: begin
            if (held_words.size() == LIST_CAP) full_reads++;
            if (held_words.size() == 0) begin
               if (record) due_results.push_back('{ola_pkg::ST_EMPTY, 32'd0, 1'b1});
            end else if (record) begin
               for (int i = 0; i < held_words.size(); i++)
                  due_results.push_back('{ola_pkg::ST_OK, held_words[i],
                                          (i == held_words.size() - 1)});
            end
         end
         default: begin
            if (record) due_results.push_back('{ola_pkg::ST_OK, 32'd0, 1'b1});
         end
      endcase
   endfunction

   // Issue one command beat, optionally after an idle gap, and wait for acceptance
   task automatic issue_command(input ola_pkg::opcode_type op, input logic [31:0] word,
                                input bit typed, input ola_pkg::status_type tst);
      if (idle_enable && $urandom_range(99) < 17) begin
         start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      start      <= 1'b1;
      req_opcode <= op;
      req_value  <= word;
      do @(posedge clock); while (busy !== 1'b0);
      apply_list_command(op, word, !typed);
      if (typed) due_results.push_back('{tst, 32'd0, 1'b1});
   endtask

   // Word mix: wide random, a small pool for duplicates, and the extremes
   function automatic logic [31:0] pick_word();
      logic [31:0] w;
      case ($urandom_range(9))
         0, 1, 2, 3: w = $urandom;
         4, 5:       w = $urandom_range(7);
         6:          w = -$urandom_range(7);
         7:          w = 32'h8000_0000;
         8:          w = 32'h7fff_ffff;
         default:    w = 32'hffff_ffff;
      endcase
      return w;
   endfunction

   // Random command under a traffic mix; most deletes hit a held word
   task automatic issue_random(input traffic_mix_type mix);
      int                  roll;
      ola_pkg::opcode_type op;
      logic [31:0]         word;
      roll = $urandom_range(99);
      word = pick_word();
      case (mix)
         MIX_GROW:   op = (roll < 80) ? ola_pkg::OP_APPEND :
                          (roll < 92) ? ola_pkg::OP_READ :
                          (roll < 98) ? ola_pkg::OP_DELETE : ola_pkg::OP_NONE;
         MIX_SHRINK: op = (roll < 15) ? ola_pkg::OP_APPEND :
                          (roll < 30) ? ola_pkg::OP_READ :
                          (roll < 97) ? ola_pkg::OP_DELETE : ola_pkg::OP_NONE;
         default:    op = (roll < 40) ? ola_pkg::OP_APPEND :
                          (roll < 60) ? ola_pkg::OP_READ :
                          (roll < 95) ? ola_pkg::OP_DELETE : ola_pkg::OP_NONE;
      endcase
      if (op == ola_pkg::OP_DELETE && held_words.size() != 0 && $urandom_range(99) < 75)
         word = held_words[$urandom_range(held_words.size() - 1)];
      issue_command(op, word, 1'b0, ola_pkg::ST_OK);
   endtask

   // Stimulus and end of run
   initial begin
      traffic_mix_type mix;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < N_ROWS; r++)
         issue_command(DIRECTED[r].op, DIRECTED[r].word, DIRECTED[r].typed, DIRECTED[r].tst);

      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if (n < 50)       mix = MIX_GROW;
         else if (n < 95)  mix = MIX_SHRINK;
         else if (n < 140) mix = MIX_ANY;
         else              mix = MIX_GROW;
         // back-to-back stretch with no idle cycles
         idle_enable = !(n >= 60 && n < 110);
         issue_random(mix);
      end
      start <= 1'b0;

      while (due_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d commands, %0d result beats checked.",
               N_ROWS + RANDOM_CMDS, results_checked);
      $display("Read-outs of a full list: %0d, appends refused as full: %0d.",
               full_reads, full_appends);
      if (error_count == 0) begin
         $display("PASS ordered_list_append_delete");
      end else begin
         $display("FAIL ordered_list_append_delete");
      end
      $finish;
   end

   // Result checker: every strobed beat against the oldest expectation
   always @(posedge clock) begin
      list_result_type exp_beat;
      if (!reset && rsp_valid === 1'b1) begin
         if (due_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result status=%0d element=%h last=%0b",
                     $time, rsp_status, rsp_element, rsp_last);
         end else begin
            exp_beat = due_results.pop_front();
            results_checked++;
            if (rsp_status !== exp_beat.status) begin
               error_count++;
               $display("%0t: status expected %0d actual %0d",
                        $time, exp_beat.status, rsp_status);
            end
            if (rsp_element !== exp_beat.element) begin
               error_count++;
               $display("%0t: element expected %h actual %h",
                        $time, exp_beat.element, rsp_element);
            end
            if (rsp_last !== exp_beat.last) begin
               error_count++;
               $display("%0t: last expected %0b actual %0b",
                        $time, exp_beat.last, rsp_last);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still due.",
                  cycle_count, due_results.size());
         $display("FAIL ordered_list_append_delete");
         $finish;
      end
   end

endmodule
